>>> hdl/hex_record_image_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hex record image parser
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_IMAGE_PARSER_UNIT_ASSERT_SVH
`define HEX_RECORD_IMAGE_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define HRIP_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrip assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HRIP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrip assertion failed");

`else

`define HRIP_ASSERT_NOW(name, clk, rst, ante, cons)
`define HRIP_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> hdl/hrip_pkg.sv
// ----------------------------------------------------------------------------
// hrip_pkg
// Shared types, codes and the hex digit decoder of the hex record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrip_pkg;

  // Parser phases
  localparam logic [2:0] PH_COLON  = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_SUM    = 3'd3;
  localparam logic [2:0] PH_END    = 3'd4;
  localparam logic [2:0] PH_HALT   = 3'd5;

  // Result kinds
  localparam logic [1:0] K_DATA   = 2'd0;
  localparam logic [1:0] K_ACCEPT = 2'd1;
  localparam logic [1:0] K_DONE   = 2'd2;
  localparam logic [1:0] K_ERROR  = 2'd3;

  // Error codes
  localparam logic [2:0] E_NO_COLON  = 3'd0;
  localparam logic [2:0] E_BAD_DIGIT = 3'd1;
  localparam logic [2:0] E_LENGTH    = 3'd2;
  localparam logic [2:0] E_ADDRESS   = 3'd3;
  localparam logic [2:0] E_TYPE      = 3'd4;
  localparam logic [2:0] E_CHECKSUM  = 3'd5;
  localparam logic [2:0] E_LINE      = 3'd6;

  // Characters and record types
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] TYPE_DATA    = 8'h00;
  localparam logic [7:0] TYPE_CLOSING = 8'h01;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_address;
    logic [2:0]  error_code;
  } result_t;

  // Bit 4 set marks a character that is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    v = 5'h10;
    if (ch >= 8'h30 && ch <= 8'h39) v = 5'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h46) v = 5'(ch - 8'h37);
    else if (ch >= 8'h61 && ch <= 8'h66) v = 5'(ch - 8'h57);
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/hrip_out_buf.sv
// ----------------------------------------------------------------------------
// hrip_out_buf
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hrip_out_buf (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  wire hrip_pkg::result_t push_data,
  output logic              ready,
  output logic              out_valid,
  input  wire               out_ready,
  output hrip_pkg::result_t out_data
);

  logic              skid_valid;
  hrip_pkg::result_t skid_data;
  logic              pop;

  assign pop   = out_valid && out_ready;
  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      if (push) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end
    end else if (!skid_valid) begin
      if (pop && push) begin
        out_data <= push_data;
      end else if (pop) begin
        out_valid <= 1'b0;
      end else if (push) begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      // skid full: no push can arrive, move skid forward
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/hex_record_image_parser_unit.sv
// ----------------------------------------------------------------------------
// hex_record_image_parser_unit
// Results are registered in the output buffer after their character transfer.
// Throughput: one character per cycle while the skid stage is empty; a held result stalls input.
// Reset: rst clears parser state, image_size and the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

// Parses a hex record text image character by character. Each line is ':',
// length, address, type, data digit pairs, checksum, LF. Data bytes are sent
// with their image offsets as they decode; a good record gives an accept at
// its LF, the closing record gives completion, any fault gives a numbered
// error. After completion or error the parser holds until a restart transfer.
// Results pass through an output register with a skid stage, so a character
// is taken while an earlier result still waits downstream.

module hex_record_image_parser_unit #(
  parameter int RECORD_BYTES = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data,    // image_size
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] character
  input  wire         s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [23:8] byte_address,
                                      // [26:24] error_code, [31:27] zero
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);

  localparam logic [7:0]  RecordCount = 8'(RECORD_BYTES);
  localparam logic [15:0] RecordWide  = 16'(RECORD_BYTES);

  // Configuration
  logic [15:0] image_size;

  // Parser state
  logic [2:0]  phase,           phase_next;
  logic [2:0]  char_position,   char_position_next;
  logic [3:0]  high_nibble,     high_nibble_next;
  logic [7:0]  record_length,   record_length_next;
  logic [15:0] record_origin,   record_origin_next;
  logic [7:0]  running_sum,     running_sum_next;
  logic [15:0] expected_offset, expected_offset_next;
  logic [7:0]  expected_count,  expected_count_next;
  logic [7:0]  bytes_left,      bytes_left_next;
  logic [15:0] data_addr,       data_addr_next;

  // Datapath
  logic              accept;
  logic              push;
  hrip_pkg::result_t result;
  hrip_pkg::result_t out_result;
  logic [4:0]        nibble;
  logic [7:0]        rec_byte;
  logic [7:0]        sum_with_byte;
  logic              closing;
  logic [16:0]       next_offset;
  logic              image_done;
  logic [15:0]       remaining;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign nibble        = hrip_pkg::hex_value(s_axis_tdata);
  assign rec_byte      = {high_nibble, nibble[3:0]};
  assign sum_with_byte = running_sum + rec_byte;
  assign closing       = (expected_count == 8'd0);

  // Offset of the following record and its expected byte count
  assign next_offset = {1'b0, expected_offset} + {9'd0, record_length};
  assign image_done  = (next_offset >= {1'b0, image_size});
  assign remaining   = image_size - next_offset[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= 16'd0;
    end else if (cfg_wr_en) begin
      image_size <= cfg_wr_data;
    end
  end

  always_comb begin
    phase_next           = phase;
    char_position_next   = char_position;
    high_nibble_next     = high_nibble;
    record_length_next   = record_length;
    record_origin_next   = record_origin;
    running_sum_next     = running_sum;
    expected_offset_next = expected_offset;
    expected_count_next  = expected_count;
    bytes_left_next      = bytes_left;
    data_addr_next       = data_addr;
    push                 = 1'b0;
    result               = '0;

    if (s_axis_tuser) begin
      // Restart: clear the parser, keep the image size
      phase_next           = hrip_pkg::PH_COLON;
      char_position_next   = 3'd0;
      high_nibble_next     = 4'd0;
      record_length_next   = 8'd0;
      record_origin_next   = 16'd0;
      running_sum_next     = 8'd0;
      expected_offset_next = 16'd0;
      expected_count_next  = RecordCount;
      bytes_left_next      = 8'd0;
    end else if (phase == hrip_pkg::PH_HALT) begin
      // hold until restart
    end else if (phase == hrip_pkg::PH_COLON) begin
      if (s_axis_tdata != hrip_pkg::CH_COLON) begin
        push              = 1'b1;
        result.kind       = hrip_pkg::K_ERROR;
        result.error_code = hrip_pkg::E_NO_COLON;
        phase_next        = hrip_pkg::PH_HALT;
      end else begin
        phase_next         = hrip_pkg::PH_HEADER;
        char_position_next = 3'd0;
        running_sum_next   = 8'd0;
      end
    end else if (phase == hrip_pkg::PH_END) begin
      push       = 1'b1;
      phase_next = hrip_pkg::PH_HALT;
      if (s_axis_tdata != hrip_pkg::CH_LF) begin
        result.kind       = hrip_pkg::K_ERROR;
        result.error_code = hrip_pkg::E_LINE;
      end else if (closing) begin
        result.kind = hrip_pkg::K_DONE;
      end else begin
        result.kind          = hrip_pkg::K_ACCEPT;
        phase_next           = hrip_pkg::PH_COLON;
        expected_offset_next = next_offset[15:0];
        if (image_done) begin
          expected_count_next = 8'd0;
        end else if (remaining < RecordWide) begin
          expected_count_next = remaining[7:0];
        end else begin
          expected_count_next = RecordCount;
        end
      end
    end else if (s_axis_tdata == hrip_pkg::CH_LF) begin
      push              = 1'b1;
      result.kind       = hrip_pkg::K_ERROR;
      result.error_code = hrip_pkg::E_LINE;
      phase_next        = hrip_pkg::PH_HALT;
    end else if (nibble[4]) begin
      push              = 1'b1;
      result.kind       = hrip_pkg::K_ERROR;
      result.error_code = hrip_pkg::E_BAD_DIGIT;
      phase_next        = hrip_pkg::PH_HALT;
    end else if (!char_position[0]) begin
      // first digit of a pair
      high_nibble_next   = nibble[3:0];
      char_position_next = char_position + 3'd1;
    end else if (phase == hrip_pkg::PH_HEADER) begin
      running_sum_next   = sum_with_byte;
      char_position_next = char_position + 3'd1;
      case (char_position[2:1])
        2'd0: begin
          record_length_next = rec_byte;
          if (rec_byte != expected_count) begin
            push              = 1'b1;
            result.kind       = hrip_pkg::K_ERROR;
            result.error_code = hrip_pkg::E_LENGTH;
            phase_next        = hrip_pkg::PH_HALT;
          end
        end
        2'd1: begin
          record_origin_next = {rec_byte, 8'd0};
        end
        2'd2: begin
          record_origin_next = {record_origin[15:8], rec_byte};
          if ({record_origin[15:8], rec_byte} != (closing ? 16'd0 : expected_offset)) begin
            push              = 1'b1;
            result.kind       = hrip_pkg::K_ERROR;
            result.error_code = hrip_pkg::E_ADDRESS;
            phase_next        = hrip_pkg::PH_HALT;
          end
        end
        default: begin
          if (rec_byte != (closing ? hrip_pkg::TYPE_CLOSING : hrip_pkg::TYPE_DATA)) begin
            push              = 1'b1;
            result.kind       = hrip_pkg::K_ERROR;
            result.error_code = hrip_pkg::E_TYPE;
            phase_next        = hrip_pkg::PH_HALT;
          end else begin
            bytes_left_next    = record_length;
            data_addr_next     = record_origin;
            char_position_next = 3'd0;
            phase_next = (record_length != 8'd0) ? hrip_pkg::PH_DATA : hrip_pkg::PH_SUM;
          end
        end
      endcase
    end else if (phase == hrip_pkg::PH_DATA) begin
      // Send the byte now; the checksum is checked at the end of the line
      push                = 1'b1;
      result.kind         = hrip_pkg::K_DATA;
      result.data_byte    = rec_byte;
      result.byte_address = data_addr;
      char_position_next  = 3'd0;
      running_sum_next    = sum_with_byte;
      bytes_left_next     = bytes_left - 8'd1;
      data_addr_next      = data_addr + 16'd1;
      if (bytes_left == 8'd1) phase_next = hrip_pkg::PH_SUM;
    end else begin
      // checksum pair
      char_position_next = 3'd0;
      if (sum_with_byte != 8'd0) begin
        push              = 1'b1;
        result.kind       = hrip_pkg::K_ERROR;
        result.error_code = hrip_pkg::E_CHECKSUM;
        phase_next        = hrip_pkg::PH_HALT;
      end else begin
        phase_next = hrip_pkg::PH_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= hrip_pkg::PH_COLON;
      char_position   <= 3'd0;
      high_nibble     <= 4'd0;
      record_length   <= 8'd0;
      record_origin   <= 16'd0;
      running_sum     <= 8'd0;
      expected_offset <= 16'd0;
      expected_count  <= RecordCount;
      bytes_left      <= 8'd0;
      data_addr       <= 16'd0;
    end else if (accept) begin
      phase           <= phase_next;
      char_position   <= char_position_next;
      high_nibble     <= high_nibble_next;
      record_length   <= record_length_next;
      record_origin   <= record_origin_next;
      running_sum     <= running_sum_next;
      expected_offset <= expected_offset_next;
      expected_count  <= expected_count_next;
      bytes_left      <= bytes_left_next;
      data_addr       <= data_addr_next;
    end
  end

  // Result register with skid stage
  hrip_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && push),
    .push_data (result),
    .ready     (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_result)
  );

  assign m_axis_tdata = {5'd0, out_result.error_code, out_result.byte_address,
                         out_result.data_byte};
  assign m_axis_tuser = out_result.kind;

  `include "hex_record_image_parser_unit_assert.svh"

  // Input stalls only while a result waits in the output register
  `HRIP_ASSERT_NOW(a_stall_has_result, clk, rst, !s_axis_tready, m_axis_tvalid)

  // A halted parser produces nothing but a restart gets through
  `HRIP_ASSERT_NOW(a_halt_silent, clk, rst,
    accept && !s_axis_tuser && phase == hrip_pkg::PH_HALT, !push)

  // Any error halts the parser
  `HRIP_ASSERT_NEXT(a_error_halts, clk, rst,
    accept && push && result.kind == hrip_pkg::K_ERROR, phase == hrip_pkg::PH_HALT)

  // Data phase always has a byte left to take
  `HRIP_ASSERT_NOW(a_data_left, clk, rst, phase == hrip_pkg::PH_DATA, bytes_left != 8'd0)

endmodule

`default_nettype wire
